[rtl/core/cls_pkg.sv]
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types and constants for the charlieplexed LED scanner.
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam int PIN_MASK_W = 8;
  localparam int SCAN_W     = 6;
  localparam int S_DATA_W   = 40;
  localparam int S_USER_W   = 2;
  localparam int M_DATA_W   = 24;

  typedef enum logic [S_USER_W-1:0] {
    OP_TICK    = 2'd0,
    OP_SET_LED = 2'd1,
    OP_SET_ALL = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [PIN_MASK_W-1:0] drive;
    logic [PIN_MASK_W-1:0] level;
  } pin_masks_t;

endpackage

[rtl/core/charlieplex_led_scanner_unit.sv]
// ----------------------------------------------------------------------------
// charlieplex_led_scanner_unit
// On/off store and scan sequencer for LEDs on NUM_PINS charlieplexed pins.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready/s_tdata with the opcode on s_tuser:
// a tick steps the scan when elapsed_ms is nonzero, set-one-LED writes one
// LED bit, set-all lights or darkens every LED. Each item yields exactly one
// result item on m_tvalid/m_tready/m_tdata carrying the pin drive mask, the
// pin level mask and the current scan position.
// Each result is registered: it enters the output register when that is free,
// else the skid register. One item is taken per cycle while the skid register
// is empty; the LED bits and the scan counters are updated as it is taken.
// Reset darkens all LEDs, sets the scan position to zero and floats all pins.
// When the receiver stalls, a second result is held in a skid register and
// s_tready drops only once both output registers are full.
// ----------------------------------------------------------------------------
module charlieplex_led_scanner_unit #(
  parameter int NUM_PINS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // led_index[7:0], led_on[8], level[16:9], elapsed_ms[32:17], zero[39:33]
  input  logic [cls_pkg::S_DATA_W-1:0]   s_tdata,
  // opcode[1:0]
  input  logic [cls_pkg::S_USER_W-1:0]   s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // drive_mask[7:0], level_mask[15:8], scan_position[21:16], zero[23:22]
  output logic [cls_pkg::M_DATA_W-1:0]   m_tdata
);
  import cls_pkg::*;

  localparam int NUM_LEDS  = NUM_PINS * (NUM_PINS - 1);
  localparam int LED_IDX_W = (NUM_LEDS > 2) ? $clog2(NUM_LEDS) : 1;
  localparam int PIN_W     = (NUM_PINS > 2) ? $clog2(NUM_PINS) : 1;

  logic [NUM_LEDS-1:0]   led_bits;
  logic [SCAN_W-1:0]     scan_index;
  logic [PIN_W-1:0]      scan_anode;
  logic [PIN_W-1:0]      scan_column;
  logic [PIN_MASK_W-1:0] pin_drive;
  logic [PIN_MASK_W-1:0] pin_level;

  logic [SCAN_W-1:0]     scan_index_next;
  logic [PIN_W-1:0]      scan_anode_next;
  logic [PIN_W-1:0]      scan_column_next;
  logic [PIN_MASK_W-1:0] pin_drive_next;
  logic [PIN_MASK_W-1:0] pin_level_next;
  logic                  step;
  logic                  lit;
  pin_masks_t            masks;

  logic [M_DATA_W-1:0]   result;
  logic [M_DATA_W-1:0]   skid_data;
  logic                  skid_valid;

  opcode_t               opcode;
  logic [7:0]            led_index;
  logic                  led_on;
  logic [7:0]            level;
  logic [15:0]           elapsed_ms;
  logic                  accept;

  assign opcode     = opcode_t'(s_tuser);
  assign led_index  = s_tdata[7:0];
  assign led_on     = s_tdata[8];
  assign level      = s_tdata[16:9];
  assign elapsed_ms = s_tdata[32:17];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  assign step = (opcode == OP_TICK) && (elapsed_ms != '0);

  always_comb begin
    if (scan_index == SCAN_W'(NUM_LEDS - 1)) begin
      scan_index_next  = '0;
      scan_anode_next  = '0;
      scan_column_next = '0;
    end else begin
      scan_index_next = SCAN_W'(scan_index + SCAN_W'(1));
      if (scan_column == PIN_W'(NUM_PINS - 2)) begin
        scan_column_next = '0;
        scan_anode_next  = PIN_W'(scan_anode + PIN_W'(1));
      end else begin
        scan_column_next = PIN_W'(scan_column + PIN_W'(1));
        scan_anode_next  = scan_anode;
      end
    end
  end

  assign lit = led_bits[scan_index_next[LED_IDX_W-1:0]];

  cls_pin_decode #(
    .PIN_W    (PIN_W)
  ) u_pin_decode (
    .anode  (scan_anode_next),
    .column (scan_column_next),
    .lit    (lit),
    .masks  (masks)
  );

  always_comb begin
    pin_drive_next = step ? masks.drive : pin_drive;
    pin_level_next = step ? masks.level : pin_level;
    result = {2'b00, (step ? scan_index_next : scan_index),
              pin_level_next & pin_drive_next, pin_drive_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_bits    <= '0;
      scan_index  <= '0;
      scan_anode  <= '0;
      scan_column <= '0;
      pin_drive   <= '0;
      pin_level   <= '0;
    end else if (accept) begin
      unique case (opcode)
        OP_SET_LED: begin
          if (led_index < 8'(NUM_LEDS)) begin
            led_bits[led_index[LED_IDX_W-1:0]] <= led_on;
          end
        end
        OP_SET_ALL: begin
          led_bits <= {NUM_LEDS{level != '0}};
        end
        OP_TICK: begin
          if (step) begin
            scan_index  <= scan_index_next;
            scan_anode  <= scan_anode_next;
            scan_column <= scan_column_next;
            pin_drive   <= pin_drive_next;
            pin_level   <= pin_level_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // hold results in the output register, overflow into the skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (accept) begin
        if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready && skid_valid) begin
      m_tdata <= skid_data;
    end else if (accept && (!m_tvalid || m_tready)) begin
      m_tdata <= result;
    end
    if (accept && m_tvalid && !m_tready) begin
      skid_data <= result;
    end
  end

endmodule

[rtl/core/cls_pin_decode.sv]
// ----------------------------------------------------------------------------
// cls_pin_decode
// Turns the anode row and cathode column of the selected LED into pin masks (empty if unlit).
// ----------------------------------------------------------------------------
module cls_pin_decode #(
  parameter int PIN_W = 3
) (
  input  logic               [PIN_W-1:0] anode,
  input  logic               [PIN_W-1:0] column,
  input  logic                           lit,
  output cls_pkg::pin_masks_t            masks
);
  import cls_pkg::*;

  logic [PIN_W-1:0] cathode;

  always_comb begin
    cathode = (column >= anode) ? PIN_W'(column + PIN_W'(1)) : column;
    masks.drive = '0;
    masks.level = '0;
    if (lit) begin
      masks.level = PIN_MASK_W'(1) << anode;
      masks.drive = masks.level | (PIN_MASK_W'(1) << cathode);
    end
  end

endmodule

[rtl/core/cls_checker.sv]
// ----------------------------------------------------------------------------
// cls_checker
// Port-level checks for the charlieplexed LED scanner, bound to the top level.
// ----------------------------------------------------------------------------
module cls_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [cls_pkg::M_DATA_W-1:0] m_tdata
);
  import cls_pkg::*;

  logic [PIN_MASK_W-1:0] drive_mask;
  logic [PIN_MASK_W-1:0] level_mask;
  logic [SCAN_W-1:0]     scan_position;

  assign drive_mask    = m_tdata[7:0];
  assign level_mask    = m_tdata[15:8];
  assign scan_position = m_tdata[21:16];

  a_level_in_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((level_mask & ~drive_mask) == '0))
    else $error("level mask outside drive mask");

  a_pin_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(drive_mask) == 0 ||
                  ($countones(drive_mask) == 2 && $countones(level_mask) == 1)))
    else $error("drive is not a single anode/cathode pair");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (scan_position <= SCAN_W'(55)))
    else $error("scan position out of range");

  a_item_accepted_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted item produced no result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind charlieplex_led_scanner_unit cls_checker u_cls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
